>>> rtl/thick_line_span_generator_unit_macros.svh
// Assertion macros used by the span generator checker.
`ifndef THICK_LINE_SPAN_GENERATOR_UNIT_MACROS_SVH
`define THICK_LINE_SPAN_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TLSG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TLSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tlsg_pkg.sv
// Shared types and constants of the thick line span generator.
package tlsg_pkg;

    localparam int DEF_COORD_BITS = 7;
    localparam int DEF_MAX_WIDTH  = 50;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic       vertical;
        logic [7:0] fixed_coord;
        logic [7:0] span_from;
        logic [7:0] span_to;
        logic [7:0] color;
    } t_span;

endpackage

>>> rtl/tlsg_core.sv
// Line state and one-step span computation of the thick line span generator.
module tlsg_core
    import tlsg_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_opcode,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic [7:0]            i_line_width,
    input  logic [7:0]            i_pen_color,
    output t_span                 o_span
);

    localparam int HALF_BITS = $clog2(MAX_WIDTH / 2 + 2);
    localparam int POS_BITS  = $clog2((2 ** COORD_BITS) + MAX_WIDTH);
    localparam int DBL_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS  = COORD_BITS + 3;
    localparam logic [7:0] WIDTH_CAP = 8'(MAX_WIDTH);
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

    typedef enum logic [2:0] {
        M_IDLE,
        M_COLS,
        M_ROWS,
        M_XMAJ,
        M_YMAJ
    } t_mode;

    function automatic logic [POS_BITS-1:0] clamp_low(input logic [POS_BITS-1:0] c,
                                                       input logic [HALF_BITS-1:0] h);
        logic [POS_BITS-1:0] hp;
        hp = POS_BITS'(h);
        return (c < hp) ? '0 : c - hp;
    endfunction

    function automatic logic [7:0] to_byte(input logic [POS_BITS-1:0] v);
        logic [POS_BITS+7:0] t;
        t = {8'h00, v};
        return t[7:0];
    endfunction

    t_mode                  r_mode, n_mode;
    logic [POS_BITS-1:0]    r_cur_x, n_cur_x;
    logic [POS_BITS-1:0]    r_cur_y, n_cur_y;
    logic [POS_BITS-1:0]    r_end, n_end;
    logic signed [ERR_BITS-1:0] r_err, n_err;
    logic [DBL_BITS-1:0]    r_tdx, n_tdx;
    logic [DBL_BITS-1:0]    r_tdy, n_tdy;
    logic                   r_x_neg, n_x_neg;
    logic                   r_y_neg, n_y_neg;
    logic [HALF_BITS-1:0]   r_hb, n_hb;
    logic [HALF_BITS-1:0]   r_ha, n_ha;
    logic [COORD_BITS-1:0]  r_held_from, n_held_from;
    logic [COORD_BITS-1:0]  r_held_to, n_held_to;
    logic [7:0]             r_color, n_color;

    logic [7:0]             w_wclamp;
    logic [HALF_BITS-1:0]   w_hb, w_ha;
    logic                   w_x_neg, w_y_neg;
    logic [COORD_BITS-1:0]  w_adx, w_ady;
    logic [POS_BITS-1:0]    w_x0, w_y0, w_x1, w_y1;
    t_span                  w_span;

    // Width clamp and split into the halves around the centre pixel.
    assign w_wclamp = (i_line_width > WIDTH_CAP) ? WIDTH_CAP : i_line_width;
    assign w_hb     = HALF_BITS'(w_wclamp >> 1);
    assign w_ha     = HALF_BITS'(w_wclamp - (w_wclamp >> 1) - 8'd1);

    assign w_x_neg = i_x_end < i_x_start;
    assign w_y_neg = i_y_end < i_y_start;
    assign w_adx   = w_x_neg ? i_x_start - i_x_end : i_x_end - i_x_start;
    assign w_ady   = w_y_neg ? i_y_start - i_y_end : i_y_end - i_y_start;
    assign w_x0    = POS_BITS'(i_x_start);
    assign w_y0    = POS_BITS'(i_y_start);
    assign w_x1    = POS_BITS'(i_x_end);
    assign w_y1    = POS_BITS'(i_y_end);

    always_comb begin : step_logic
        logic v_last;
        logic signed [ERR_BITS-1:0] v_tdx_e, v_tdy_e;
        v_last      = 1'b0;
        n_mode      = r_mode;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_end       = r_end;
        n_err       = r_err;
        n_tdx       = r_tdx;
        n_tdy       = r_tdy;
        n_x_neg     = r_x_neg;
        n_y_neg     = r_y_neg;
        n_hb        = r_hb;
        n_ha        = r_ha;
        n_held_from = r_held_from;
        n_held_to   = r_held_to;
        n_color     = r_color;
        w_span      = '0;

        // Start: load the new line, or drop to idle on zero width.
        if (i_valid && (i_opcode == OP_START)) begin
            n_mode = M_IDLE;
            if (i_line_width != 8'd0) begin
                n_color = i_pen_color;
                n_hb    = w_hb;
                n_ha    = w_ha;
                if (i_x_start == i_x_end) begin
                    n_cur_x     = clamp_low(w_x0, w_hb);
                    n_end       = w_x0 + POS_BITS'(w_ha);
                    n_cur_y     = w_y0;
                    n_held_from = i_y_start;
                    n_held_to   = i_y_end;
                    n_mode      = M_COLS;
                end else if (i_y_start == i_y_end) begin
                    n_cur_y     = clamp_low(w_y0, w_hb);
                    n_end       = w_y0 + POS_BITS'(w_ha);
                    n_cur_x     = w_x0;
                    n_held_from = i_x_start;
                    n_held_to   = i_x_end;
                    n_mode      = M_ROWS;
                end else begin
                    n_x_neg = w_x_neg;
                    n_y_neg = w_y_neg;
                    n_tdx   = {w_adx, 1'b0};
                    n_tdy   = {w_ady, 1'b0};
                    n_cur_x = w_x0;
                    n_cur_y = w_y0;
                    if (w_adx >= w_ady) begin
                        n_err  = $signed(ERR_BITS'({w_ady, 1'b0}))
                                 - $signed(ERR_BITS'(w_adx));
                        n_end  = w_x1;
                        n_mode = M_XMAJ;
                    end else begin
                        n_err  = $signed(ERR_BITS'({w_adx, 1'b0}))
                                 - $signed(ERR_BITS'(w_ady));
                        n_end  = w_y1;
                        n_mode = M_YMAJ;
                    end
                end
            end
        end

        // Doubled deltas of the line in force, widened for the decision update.
        v_tdx_e = $signed(ERR_BITS'(n_tdx));
        v_tdy_e = $signed(ERR_BITS'(n_tdy));

        // Emit the span at the current point and advance.
        if (i_valid) begin
            unique case (n_mode)
                M_COLS: begin
                    v_last             = n_cur_x >= n_end;
                    w_span.valid       = 1'b1;
                    w_span.last        = v_last;
                    w_span.vertical    = 1'b1;
                    w_span.fixed_coord = to_byte(n_cur_x);
                    w_span.span_from   = to_byte(POS_BITS'(n_held_from));
                    w_span.span_to     = to_byte(POS_BITS'(n_held_to));
                    w_span.color       = n_color;
                    if (v_last) begin
                        n_mode = M_IDLE;
                    end else begin
                        n_cur_x = n_cur_x + POS_ONE;
                    end
                end
                M_ROWS: begin
                    v_last             = n_cur_y >= n_end;
                    w_span.valid       = 1'b1;
                    w_span.last        = v_last;
                    w_span.vertical    = 1'b0;
                    w_span.fixed_coord = to_byte(n_cur_y);
                    w_span.span_from   = to_byte(POS_BITS'(n_held_from));
                    w_span.span_to     = to_byte(POS_BITS'(n_held_to));
                    w_span.color       = n_color;
                    if (v_last) begin
                        n_mode = M_IDLE;
                    end else begin
                        n_cur_y = n_cur_y + POS_ONE;
                    end
                end
                M_XMAJ: begin
                    v_last             = n_cur_x == n_end;
                    w_span.valid       = 1'b1;
                    w_span.last        = v_last;
                    w_span.vertical    = 1'b1;
                    w_span.fixed_coord = to_byte(n_cur_x);
                    w_span.span_from   = to_byte(clamp_low(n_cur_y, n_hb));
                    w_span.span_to     = to_byte(n_cur_y + POS_BITS'(n_ha));
                    w_span.color       = n_color;
                    if (v_last) begin
                        n_mode = M_IDLE;
                    end else begin
                        n_cur_x = n_x_neg ? n_cur_x - POS_ONE : n_cur_x + POS_ONE;
                        if (n_err[ERR_BITS-1]) begin
                            n_err = n_err + v_tdy_e;
                        end else begin
                            n_err   = n_err + (v_tdy_e - v_tdx_e);
                            n_cur_y = n_y_neg ? n_cur_y - POS_ONE : n_cur_y + POS_ONE;
                        end
                    end
                end
                M_YMAJ: begin
                    v_last             = n_cur_y == n_end;
                    w_span.valid       = 1'b1;
                    w_span.last        = v_last;
                    w_span.vertical    = 1'b0;
                    w_span.fixed_coord = to_byte(n_cur_y);
                    w_span.span_from   = to_byte(clamp_low(n_cur_x, n_hb));
                    w_span.span_to     = to_byte(n_cur_x + POS_BITS'(n_ha));
                    w_span.color       = n_color;
                    if (v_last) begin
                        n_mode = M_IDLE;
                    end else begin
                        n_cur_y = n_y_neg ? n_cur_y - POS_ONE : n_cur_y + POS_ONE;
                        if (n_err[ERR_BITS-1]) begin
                            n_err = n_err + v_tdx_e;
                        end else begin
                            n_err   = n_err + (v_tdx_e - v_tdy_e);
                            n_cur_x = n_x_neg ? n_cur_x - POS_ONE : n_cur_x + POS_ONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_span = w_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_end       <= '0;
            r_err       <= '0;
            r_tdx       <= '0;
            r_tdy       <= '0;
            r_x_neg     <= 1'b0;
            r_y_neg     <= 1'b0;
            r_hb        <= '0;
            r_ha        <= '0;
            r_held_from <= '0;
            r_held_to   <= '0;
            r_color     <= '0;
        end else begin
            r_mode      <= n_mode;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_end       <= n_end;
            r_err       <= n_err;
            r_tdx       <= n_tdx;
            r_tdy       <= n_tdy;
            r_x_neg     <= n_x_neg;
            r_y_neg     <= n_y_neg;
            r_hb        <= n_hb;
            r_ha        <= n_ha;
            r_held_from <= n_held_from;
            r_held_to   <= n_held_to;
            r_color     <= n_color;
        end
    end

endmodule

>>> rtl/thick_line_span_generator_unit.sv
// Top level of the thick line span generator: input and result registers around the core.
//
// Usage:
//   Slave channel (i_s_*): one command item per handshake. tuser is the opcode
//   (start = 0, advance = 1); tdata carries the end points, width and color.
//   A start loads a new line and returns its first span; each advance returns
//   the next span. Every accepted item returns exactly one result item.
//   Master channel (o_m_*): tuser[0] says whether the result holds a span,
//   tuser[1] whether that span is vertical, tlast marks the final span.
//   A result without a span has every other field zero.
// Pipeline and throughput:
//   An item sits in the input register while the core works its span with
//   add/compare logic; the span enters the result register when that register
//   is free, which raises o_m_tvalid. One item per cycle is taken sustained
//   while the receiver keeps up; the Bresenham step in the core is the only loop.
// Reset and stall:
//   i_rst_n low (synchronous) empties both registers and returns the line
//   state to idle. While the receiver stalls, the result is held and one more
//   item may still be taken into the input register; then o_s_tready drops.
module thick_line_span_generator_unit
    import tlsg_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    localparam int IN_FIELD_BITS = 4 * COORD_BITS + 16,
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // x_start, y_start, x_end, y_end, line_width, pen_color (lowest bit up)
    input  logic [IN_DATA_BITS-1:0] i_s_tdata,
    // opcode
    input  logic                    i_s_tuser,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // fixed_coord, span_from, span_to, span_color (lowest bit up)
    output logic [31:0]             o_m_tdata,
    // span_valid, span_vertical (lowest bit up)
    output logic [1:0]              o_m_tuser,
    output logic                    o_m_tlast
);

    localparam int C = COORD_BITS;

    logic                     r_in_valid;
    logic                     r_in_op;
    logic [IN_FIELD_BITS-1:0] r_in_data;
    logic                     r_out_valid;
    t_span                    r_span;
    logic                     w_adv;
    t_span                    w_span;

    // Move the input item into the core when the result register is free.
    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // Hold the payload unless a new item is taken.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op   <= i_s_tuser;
            r_in_data <= i_s_tdata[IN_FIELD_BITS-1:0];
        end
    end

    tlsg_core #(
        .COORD_BITS (COORD_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid && w_adv),
        .i_opcode     (r_in_op),
        .i_x_start    (r_in_data[C-1:0]),
        .i_y_start    (r_in_data[2*C-1:C]),
        .i_x_end      (r_in_data[3*C-1:2*C]),
        .i_y_end      (r_in_data[4*C-1:3*C]),
        .i_line_width (r_in_data[4*C+7:4*C]),
        .i_pen_color  (r_in_data[4*C+15:4*C+8]),
        .o_span       (w_span)
    );

    // Result register: load on advance, hold while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_span <= w_span;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_span.color, r_span.span_to, r_span.span_from, r_span.fixed_coord};
    assign o_m_tuser  = {r_span.vertical, r_span.valid};
    assign o_m_tlast  = r_span.last;

endmodule

>>> rtl/tlsg_checker.sv
// Port-level checker for the thick line span generator, bound to the top level.
`include "thick_line_span_generator_unit_macros.svh"

module tlsg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // A result without a span carries nothing else.
    `TLSG_ASSERT_SAME(a_empty_is_zero, o_m_tvalid && !o_m_tuser[0],
        (o_m_tdata == 32'd0) && !o_m_tlast && !o_m_tuser[1], "empty result not zero")

    // The end of a line is always a real span.
    `TLSG_ASSERT_SAME(a_last_has_span, o_m_tvalid && o_m_tlast, o_m_tuser[0],
        "last flag on empty result")

    `TLSG_ASSERT_NEXT(a_valid_holds, o_m_tvalid && !i_m_tready, o_m_tvalid,
        "result dropped while stalled")

    `TLSG_ASSERT_NEXT(a_data_holds, o_m_tvalid && !i_m_tready,
        $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast),
        "result changed while stalled")

endmodule

bind thick_line_span_generator_unit tlsg_checker u_tlsg_checker (.*);

>>> tb/thick_line_span_generator_unit_tb.sv
// Self-checking testbench for the thick line span generator unit.
module thick_line_span_generator_unit_tb;

    import tlsg_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // Random command items per handshake phase; four phases in all.
    localparam int PHASE_ITEMS = 213;
    // Cycles to wait after the last span: the pipeline latency plus margin.
    localparam int DRAIN_CYCLES = 8;

    // Line predictor and store of expected spans.
    class span_scoreboard;
        typedef enum int {LINE_IDLE, LINE_COLS, LINE_ROWS, LINE_XMAJ, LINE_YMAJ} line_mode_e;

        line_mode_e mode = LINE_IDLE;
        int         cur_x = 0, cur_y = 0, end_major = 0, decision = 0;
        int         twice_dx = 0, twice_dy = 0;
        bit         x_backward = 0, y_backward = 0;
        int         half_below = 0, half_above = 0, held_from = 0, held_to = 0;
        logic [7:0] line_color = '0;
        t_span      expected_spans[$];
        int         errors = 0;

        function bit busy();
            return mode != LINE_IDLE;
        endfunction

        function int pending();
            return expected_spans.size();
        endfunction

        // Lower span end, clamped at zero; the upper end is never clamped.
        function int low_edge(int c);
            int v;
            v = c - half_below;
            return (v < 0) ? 0 : v;
        endfunction

        function t_span make_span(bit last, bit vert, int fixed, int from, int upto);
            t_span s;
            s.valid       = 1'b1;
            s.last        = last;
            s.vertical    = vert;
            s.fixed_coord = 8'(fixed);
            s.span_from   = 8'(from);
            s.span_to     = 8'(upto);
            s.color       = line_color;
            return s;
        endfunction

        // Note one accepted command item and queue the span it returns.
        function void note_command(logic op, logic [6:0] xs, logic [6:0] ys, logic [6:0] xe,
                                   logic [6:0] ye, logic [7:0] width, logic [7:0] color);
            t_span res;
            int    w, dx, dy;
            bit    last;
            res = '0;
            if (op == OP_START) begin
                mode = LINE_IDLE;
                if (width == 0) begin
                    expected_spans.push_back(res);
                    return;
                end
                w = (width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width);
                line_color = color;
                half_below = w / 2;
                half_above = w - half_below - 1;
                dx = int'(xe) - int'(xs);
                dy = int'(ye) - int'(ys);
                if (dx == 0) begin
                    cur_x     = low_edge(xs);
                    end_major = xs + half_above;
                    cur_y     = ys;
                    held_from = ys;
                    held_to   = ye;
                    mode      = LINE_COLS;
                end else if (dy == 0) begin
                    cur_y     = low_edge(ys);
                    end_major = ys + half_above;
                    cur_x     = xs;
                    held_from = xs;
                    held_to   = xe;
                    mode      = LINE_ROWS;
                end else begin
                    x_backward = dx < 0;
                    y_backward = dy < 0;
                    if (dx < 0) dx = -dx;
                    if (dy < 0) dy = -dy;
                    twice_dx = 2 * dx;
                    twice_dy = 2 * dy;
                    cur_x    = xs;
                    cur_y    = ys;
                    if (dx >= dy) begin
                        decision  = twice_dy - dx;
                        end_major = xe;
                        mode      = LINE_XMAJ;
                    end else begin
                        decision  = twice_dx - dy;
                        end_major = ye;
                        mode      = LINE_YMAJ;
                    end
                end
            end
            case (mode)
                LINE_COLS: begin
                    last = cur_x >= end_major;
                    res  = make_span(last, 1'b1, cur_x, held_from, held_to);
                    if (last) mode = LINE_IDLE;
                    else cur_x++;
                end
                LINE_ROWS: begin
                    last = cur_y >= end_major;
                    res  = make_span(last, 1'b0, cur_y, held_from, held_to);
                    if (last) mode = LINE_IDLE;
                    else cur_y++;
                end
                LINE_XMAJ: begin
                    last = cur_x == end_major;
                    res  = make_span(last, 1'b1, cur_x, low_edge(cur_y), cur_y + half_above);
                    if (last) begin
                        mode = LINE_IDLE;
                    end else begin
                        cur_x += x_backward ? -1 : 1;
                        if (decision < 0) begin
                            decision += twice_dy;
                        end else begin
                            decision += twice_dy - twice_dx;
                            cur_y += y_backward ? -1 : 1;
                        end
                    end
                end
                LINE_YMAJ: begin
                    last = cur_y == end_major;
                    res  = make_span(last, 1'b0, cur_y, low_edge(cur_x), cur_x + half_above);
                    if (last) begin
                        mode = LINE_IDLE;
                    end else begin
                        cur_y += y_backward ? -1 : 1;
                        if (decision < 0) begin
                            decision += twice_dx;
                        end else begin
                            decision += twice_dx - twice_dy;
                            cur_x += x_backward ? -1 : 1;
                        end
                    end
                end
                default: ;
            endcase
            expected_spans.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
            if (got_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            end
        endfunction

        // Check one accepted result item against the oldest expected span.
        function void check_result(t_span got);
            t_span exp_s;
            if (expected_spans.size() == 0) begin
                errors++;
                $display("%0t: result %h arrived with no span expected", $time, got);
                return;
            end
            exp_s = expected_spans.pop_front();
            compare_field("span_valid", exp_s.valid, got.valid);
            compare_field("span_last", exp_s.last, got.last);
            compare_field("span_vertical", exp_s.vertical, got.vertical);
            compare_field("fixed_coord", exp_s.fixed_coord, got.fixed_coord);
            compare_field("span_from", exp_s.span_from, got.span_from);
            compare_field("span_to", exp_s.span_to, got.span_to);
            compare_field("span_color", exp_s.color, got.color);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    span_scoreboard spans = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cmd_count = 0;
    int line_count = 0;
    int span_count = 0;
    int quiet_cycles = 0;

    always #2 clk = ~clk;

    thick_line_span_generator_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    // Receiver: stall at random at the rate of the current phase.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor: outputs are read before this edge's updates land.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            spans.check_result('{valid: m_tuser[0], last: m_tlast, vertical: m_tuser[1],
                                 fixed_coord: m_tdata[7:0], span_from: m_tdata[15:8],
                                 span_to: m_tdata[23:16], color: m_tdata[31:24]});
            span_count++;
        end
    end

    // Watchdog: end the run when no handshake happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d spans outstanding",
                         $time, STALL_LIMIT, spans.pending());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Offer one command item, idling first at the phase rate; hold until accepted.
    task automatic send_cmd(input logic op, input logic [6:0] xs, input logic [6:0] ys,
                            input logic [6:0] xe, input logic [6:0] ye,
                            input logic [7:0] width, input logic [7:0] color);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, color, width, ye, xe, ys, xs};
        do @(posedge clk); while (!s_tready);
        spans.note_command(op, xs, ys, xe, ye, width, color);
        cmd_count++;
        if (op == OP_START) line_count++;
    endtask

    // Advance with random, ignored payload.
    task automatic send_advance();
        send_cmd(OP_ADVANCE, 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                 8'($urandom), 8'($urandom));
    endtask

    // Start a line, then advance until it ends or max_adv advances are spent.
    task automatic draw_line(input logic [6:0] xs, input logic [6:0] ys, input logic [6:0] xe,
                             input logic [6:0] ye, input logic [7:0] width,
                             input logic [7:0] color, input int max_adv);
        int n;
        n = 0;
        send_cmd(OP_START, xs, ys, xe, ye, width, color);
        while (spans.busy() && n < max_adv) begin
            send_advance();
            n++;
        end
    endtask

    // Hold off the sender until every expected span has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (spans.pending() > 0) @(posedge clk);
    endtask

    function automatic logic [6:0] near_coord(int base);
        int v;
        v = base + $urandom_range(0, 24) - 12;
        if (v < 0) v = 0;
        if (v > 127) v = 127;
        return 7'(v);
    endfunction

    function automatic logic [7:0] pick_width();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 8'd0;
        if (r < 70) return 8'($urandom_range(1, 6));
        if (r < 88) return 8'($urandom_range(7, 50));
        return 8'($urandom_range(51, 255));
    endfunction

    // One random line: mostly well-formed, shortish, with every line kind.
    task automatic random_line();
        logic [6:0] xs, ys, xe, ye;
        int         kind, max_adv;
        xs = ($urandom_range(3) == 0) ? 7'($urandom_range(0, 4)) : 7'($urandom);
        ys = ($urandom_range(3) == 0) ? 7'($urandom_range(0, 4)) : 7'($urandom);
        if ($urandom_range(9) < 7) begin
            xe = near_coord(xs);
            ye = near_coord(ys);
        end else begin
            xe = 7'($urandom);
            ye = 7'($urandom);
        end
        kind = $urandom_range(9);
        if (kind < 2) xe = xs;
        else if (kind < 4) ye = ys;
        else if (kind == 4) begin
            xe = xs;
            ye = ys;
        end
        // Cut a few lines short so the next start abandons them.
        max_adv = ($urandom_range(9) == 0) ? $urandom_range(0, 5) : 1000;
        draw_line(xs, ys, xe, ye, pick_width(), 8'($urandom), max_adv);
    endtask

    // Noise: stray advances and random starts with no line-shape bias.
    task automatic noise_items();
        int k;
        k = $urandom_range(1, 3);
        repeat (k) begin
            if ($urandom_range(1) == 0) begin
                send_advance();
            end else begin
                send_cmd(OP_START, 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                         ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        int phase, target;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling.
        send_advance();                                              // advance while idle
        send_cmd(OP_START, 7'd10, 7'd10, 7'd20, 7'd30, 8'd0, 8'hFF); // zero width
        draw_line(7'd10, 7'd5, 7'd10, 7'd20, 8'd1, 8'h00, 1000);     // vertical, one column
        draw_line(7'd0, 7'd0, 7'd0, 7'd0, 8'd255, 8'hA5, 3);         // point, clamped width
        draw_line(7'd0, 7'd127, 7'd127, 7'd127, 8'd4, 8'h5A, 1000);  // horizontal, top rows
        draw_line(7'd127, 7'd0, 7'd0, 7'd5, 8'd2, 8'hFF, 2);         // x-major, backward
        send_cmd(OP_START, 7'd1, 7'd1, 7'd5, 7'd5, 8'd0, 8'h11);     // zero width drops line
        send_advance();
        draw_line(7'd0, 7'd0, 7'd3, 7'd127, 8'd51, 8'h3C, 2);        // y-major, start abandons
        draw_line(7'd127, 7'd127, 7'd124, 7'd125, 8'd50, 8'hC3, 1000);
        drain();

        // Random part in four handshake phases.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            target = cmd_count + PHASE_ITEMS;
            while (cmd_count < target) begin
                if ($urandom_range(99) < 80) random_line();
                else noise_items();
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        spans.errors += spans.pending();

        $display("Sent %0d command items starting %0d lines; checked %0d span results",
                 cmd_count, line_count, span_count);
        $display("Phases: free flow, sparse sender, stalling receiver, mixed idling");
        if (spans.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
